@@ sv/dpd_pkg.sv @@
// shared types, constants and header decode helpers for the position packet decoder
package dpd_pkg;

  // configuration register indexes
  localparam logic CFG_HIGH_PRECISION = 1'b0;
  localparam logic CFG_SHORT_X        = 1'b1;

  localparam logic [7:0] LO_X_PRESENT = 8'h10;
  localparam logic [7:0] LO_Y_PRESENT = 8'h20;
  localparam logic [7:0] LO_STAMP16   = 8'h40;
  localparam logic [7:0] LO_IDENT24   = 8'h80;
  localparam logic [15:0] X_ABSENT    = 16'h1000;

  localparam logic [2:0] EL_NONE  = 3'd0;
  localparam logic [2:0] EL_Y8    = 3'd1;
  localparam logic [2:0] EL_Y16   = 3'd2;
  localparam logic [2:0] EL_XY8   = 3'd3;
  localparam logic [2:0] EL_XY16  = 3'd4;
  localparam logic [2:0] EL_XZERO = 3'd5;

  localparam logic [2:0] ST_SUB8    = 3'd0;
  localparam logic [2:0] ST_SUB8HI  = 3'd1;
  localparam logic [2:0] ST_SUB16   = 3'd2;
  localparam logic [2:0] ST_SUB15   = 3'd3;
  localparam logic [2:0] ST_RAW15   = 3'd4;
  localparam logic [2:0] ST_RAW23   = 3'd5;
  localparam logic [2:0] ST_IDENT24 = 3'd6;
  localparam logic [2:0] ST_NONE    = 3'd7;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_STAMP  = 2'd3;

  typedef struct packed {
    logic [2:0] first;
    logic [2:0] second;
    logic [2:0] form;
  } hcode_t;

  typedef struct packed {
    logic [2:0] l1;
    logic [2:0] l2;
    logic [2:0] l3;
  } seg_len_t;

  // one complete packet as handed from the parser to the decoder
  typedef struct packed {
    logic [7:0]      header;
    logic            hi;
    logic            short_x;
    logic [3:0][7:0] e1;
    logic [3:0][7:0] e2;
    logic [4:0][7:0] st;
  } pkt_t;

  // base-6 digits of the header via reciprocal multiply, exact for 8-bit values
  function automatic hcode_t split_header(input logic [7:0] h);
    logic [15:0] p6;
    logic [5:0]  q6;
    logic [15:0] p36;
    logic [2:0]  q36;
    hcode_t      r;
    p6  = 16'(h) * 16'd171;
    q6  = p6[15:10];
    p36 = 16'(q6) * 16'd171;
    q36 = p36[12:10];
    r.first  = 3'(h - 8'(q6) * 8'd6);
    r.second = 3'(q6 - 6'(q36) * 6'd6);
    r.form   = q36;
    return r;
  endfunction

  function automatic logic [2:0] elem_len(input logic [2:0] c, input logic sx);
    logic [2:0] r;
    unique case (c)
      EL_Y8:   r = 3'd1;
      EL_Y16:  r = 3'd2;
      EL_XY8:  r = sx ? 3'd2 : 3'd3;
      EL_XY16: r = sx ? 3'd3 : 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] stamp_len(input logic [2:0] f);
    logic [2:0] r;
    unique case (f)
      ST_SUB8, ST_SUB8HI:  r = 3'd1;
      ST_SUB16:            r = 3'd2;
      ST_SUB15, ST_RAW15:  r = 3'd3;
      ST_RAW23:            r = 3'd4;
      ST_IDENT24:          r = 3'd5;
      default:             r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic seg_len_t seg_lens(input logic [7:0] h, input logic hi,
                                        input logic sx);
    hcode_t   c;
    seg_len_t r;
    c = split_header(h);
    if (hi) begin
      r.l1 = elem_len(c.first, sx);
      r.l2 = elem_len(c.second, sx);
      r.l3 = stamp_len(c.form);
    end else begin
      r.l1 = |(h & LO_X_PRESENT) ? 3'd2 : 3'd0;
      r.l2 = |(h & LO_Y_PRESENT) ? 3'd2 : 3'd0;
      r.l3 = (|(h & LO_STAMP16) ? 3'd2 : 3'd1) + (|(h & LO_IDENT24) ? 3'd3 : 3'd2);
    end
    return r;
  endfunction

endpackage

@@ sv/dpd_front.sv @@
// byte parser: tracks segments of the current packet and emits whole packets
module dpd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          high_precision,
  input  logic          short_x_mode,
  input  logic          byte_valid,
  input  logic [7:0]    data_byte,
  input  logic          room,
  output logic          push,
  output dpd_pkg::pkt_t pkt
);

  logic [1:0]      phase, phase_next;
  logic [2:0]      cnt, cnt_next;
  logic [7:0]      header;
  logic            hi, sx;
  logic [3:0][7:0] e1, e2, e1_next, e2_next;
  logic [4:0][7:0] st, st_next;
  logic [7:0]      h_cur;
  logic            hi_cur, sx_cur;
  dpd_pkg::seg_len_t lens;
  logic [2:0]      cur_len;
  logic            seg_done;
  logic            emit;
  logic            take;

  assign take = byte_valid && room;

  always_comb begin
    h_cur  = (phase == dpd_pkg::PH_HEADER) ? data_byte : header;
    hi_cur = (phase == dpd_pkg::PH_HEADER) ? high_precision : hi;
    sx_cur = (phase == dpd_pkg::PH_HEADER) ? short_x_mode : sx;
    lens   = dpd_pkg::seg_lens(h_cur, hi_cur, sx_cur);
    e1_next = e1;
    e2_next = e2;
    st_next = st;
    unique case (phase)
      dpd_pkg::PH_FIRST:  begin
        cur_len = lens.l1;
        e1_next[cnt[1:0]] = data_byte;
      end
      dpd_pkg::PH_SECOND: begin
        cur_len = lens.l2;
        e2_next[cnt[1:0]] = data_byte;
      end
      dpd_pkg::PH_STAMP:  begin
        cur_len = lens.l3;
        if (cnt < 3'd5) st_next[cnt] = data_byte;
      end
      default: cur_len = 3'd0;
    endcase
    seg_done = (phase == dpd_pkg::PH_HEADER) || (cnt + 3'd1 == cur_len);
    // skip empty segments; a packet may finish on its header byte
    emit = 1'b0;
    cnt_next = seg_done ? 3'd0 : cnt + 3'd1;
    phase_next = phase;
    if (seg_done) begin
      priority if (phase == dpd_pkg::PH_HEADER && lens.l1 != 3'd0) begin
        phase_next = dpd_pkg::PH_FIRST;
      end else if (phase != dpd_pkg::PH_STAMP && phase != dpd_pkg::PH_SECOND &&
                   lens.l2 != 3'd0) begin
        phase_next = dpd_pkg::PH_SECOND;
      end else if (phase != dpd_pkg::PH_STAMP && lens.l3 != 3'd0) begin
        phase_next = dpd_pkg::PH_STAMP;
      end else begin
        phase_next = dpd_pkg::PH_HEADER;
        emit = 1'b1;
      end
    end
  end

  assign push = take && emit;

  always_comb begin
    pkt.header  = h_cur;
    pkt.hi      = hi_cur;
    pkt.short_x = sx_cur;
    pkt.e1      = e1_next;
    pkt.e2      = e2_next;
    pkt.st      = st_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= dpd_pkg::PH_HEADER;
      cnt    <= 3'd0;
      header <= 8'd0;
      hi     <= 1'b0;
      sx     <= 1'b0;
    end else if (take) begin
      phase  <= phase_next;
      cnt    <= cnt_next;
      header <= h_cur;
      hi     <= hi_cur;
      sx     <= sx_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      e1 <= e1_next;
      e2 <= e2_next;
      st <= st_next;
    end
  end

endmodule

@@ sv/dpd_queue.sv @@
// two-entry packet queue between parser and decoder
module dpd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dpd_pkg::pkt_t wr_pkt,
  output logic          room,
  input  logic          pop,
  output logic          avail,
  output dpd_pkg::pkt_t rd_pkt
);

  dpd_pkg::pkt_t mem [2];
  logic       wp, rp;
  logic [1:0] count;

  assign room   = (count != 2'd2);
  assign avail  = (count != 2'd0);
  assign rd_pkt = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_pkt;
  end

endmodule

@@ sv/dpd_back.sv @@
// packet decoder: element and stamp decode, running stamp, output register
module dpd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          avail,
  input  dpd_pkg::pkt_t pkt,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [151:0]  out_data
);

  typedef struct packed {
    logic [15:0] dx;
    logic [15:0] dy;
  } elem_t;

  function automatic elem_t dec_elem(input logic [2:0] c, input logic sx,
                                     input logic [3:0][7:0] e);
    elem_t r;
    r.dx = dpd_pkg::X_ABSENT;
    r.dy = 16'd0;
    unique case (c)
      dpd_pkg::EL_Y8:  r.dy = {{8{e[0][7]}}, e[0]};
      dpd_pkg::EL_Y16: r.dy = {e[0], e[1]};
      dpd_pkg::EL_XY8: begin
        if (sx) begin
          r.dx = (16'(e[0]) + 16'd1) << 5;
          r.dy = {{8{e[1][7]}}, e[1]};
        end else begin
          r.dx = {e[0], e[1]};
          r.dy = {{8{e[2][7]}}, e[2]};
        end
      end
      dpd_pkg::EL_XY16: begin
        if (sx) begin
          r.dx = (16'(e[0]) + 16'd1) << 5;
          r.dy = {e[1], e[2]};
        end else begin
          r.dx = {e[0], e[1]};
          r.dy = {e[2], e[3]};
        end
      end
      dpd_pkg::EL_XZERO: r.dx = 16'd0;
      default: ;
    endcase
    return r;
  endfunction

  logic [31:0] running;
  logic [31:0] run_next;
  dpd_pkg::hcode_t c;
  elem_t       el1, el2;
  logic [31:0] val;
  logic [16:0] sh;
  logic [15:0] be0;
  logic [31:0] fx, sx2;
  logic [31:0] fy, sy;
  logic        id3;

  always_comb begin
    c   = dpd_pkg::split_header(pkt.header);
    be0 = {pkt.st[0], pkt.st[1]};
    run_next = running;
    val = 32'd0;
    sh  = 17'd0;
    el1 = dec_elem(c.first, pkt.short_x, pkt.e1);
    el2 = dec_elem(c.second, pkt.short_x, pkt.e2);
    id3 = |(pkt.header & dpd_pkg::LO_IDENT24);
    if (pkt.hi) begin
      fy = {el1.dy, 16'd0};
      sy = {el2.dy, 16'd0};
      unique case (c.form)
        dpd_pkg::ST_SUB8: begin
          sh = 17'(pkt.st[0]);
          run_next = running - 32'(sh);
          val = run_next;
        end
        dpd_pkg::ST_SUB8HI: begin
          sh = 17'(pkt.st[0]) + 17'h100;
          run_next = running - 32'(sh);
          val = run_next;
        end
        dpd_pkg::ST_SUB16: begin
          sh = 17'(be0);
          run_next = running - 32'(sh);
          val = run_next;
        end
        dpd_pkg::ST_SUB15: begin
          sh = 17'(be0 >> 7);
          run_next = running - 32'({pkt.st[1][6:0], pkt.st[2]});
          val = run_next;
        end
        dpd_pkg::ST_RAW15: begin
          sh  = 17'(be0 >> 7);
          val = 32'({pkt.st[1][6:0], pkt.st[2]});
        end
        dpd_pkg::ST_RAW23: begin
          sh  = 17'(be0 >> 7);
          val = 32'({pkt.st[1][6:0], pkt.st[2], pkt.st[3]});
        end
        dpd_pkg::ST_IDENT24: begin
          sh  = 17'(be0);
          val = 32'({pkt.st[2], pkt.st[3], pkt.st[4]});
        end
        default: ;
      endcase
    end else begin
      // fixed fields: x and y only, y lands in the second x slot
      el1.dx = |(pkt.header & dpd_pkg::LO_X_PRESENT) ? {pkt.e1[0], pkt.e1[1]}
                                                     : dpd_pkg::X_ABSENT;
      el2.dx = |(pkt.header & dpd_pkg::LO_Y_PRESENT) ? {pkt.e2[0], pkt.e2[1]}
                                                     : dpd_pkg::X_ABSENT;
      fy = 32'd0;
      sy = 32'd0;
      if (|(pkt.header & dpd_pkg::LO_STAMP16)) begin
        sh  = 17'(be0);
        val = id3 ? 32'({pkt.st[2], pkt.st[3], pkt.st[4]})
                  : 32'({pkt.st[2], pkt.st[3]});
      end else begin
        sh  = 17'(pkt.st[0]);
        val = id3 ? 32'({pkt.st[1], pkt.st[2], pkt.st[3]})
                  : 32'({pkt.st[1], pkt.st[2]});
      end
    end
    fx  = 32'({el1.dx, 4'd0});
    sx2 = 32'({el2.dx, 4'd0});
  end

  assign pop = avail && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      running   <= 32'd0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        running   <= run_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= {sh[15:0], val, sy, sx2[19:0], fy, fx[19:0]};
    end
  end

endmodule

@@ sv/delta_position_packet_decoder_unit.sv @@
// top level of the delta position packet decoder
// The unit takes one byte per cycle on the s_ side while the queue has room and gives one
// decoded packet on the m_ side on the byte that completes it (possibly the header byte
// itself). A byte-serial parser fills per-segment byte buffers and hands each finished
// packet to a two-entry queue; the decoder behind it works out elements and stamp, updates
// the running 32-bit stamp and holds the result in an output register. Sustained rate is
// one byte per cycle while the queue has room; a packet's result passes through the queue
// and then the output register. Both mode registers are sampled on a packet's header byte
// and govern that whole packet; write them only while the unit is idle.
module delta_position_packet_decoder_unit (
  input  logic         clk,
  input  logic         rst,
  // configuration: index 0 high_precision, index 1 short_x_mode
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic         cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // first_x[19:0], first_y[51:20], second_x[71:52], second_y[103:72],
  // stamp_or_ident[135:104], short_stamp[151:136]
  output logic [151:0] m_tdata
);

  logic          high_precision, short_x_mode;
  logic          room, push, avail, pop;
  dpd_pkg::pkt_t wr_pkt, rd_pkt;

  // mode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_precision <= 1'b0;
      short_x_mode   <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == dpd_pkg::CFG_HIGH_PRECISION) high_precision <= cfg_data;
      if (cfg_index == dpd_pkg::CFG_SHORT_X) short_x_mode <= cfg_data;
    end
  end

  // a byte is taken whenever the queue can hold a packet it might complete
  assign s_tready = room;

  dpd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .high_precision (high_precision),
    .short_x_mode   (short_x_mode),
    .byte_valid     (s_tvalid),
    .data_byte      (s_tdata),
    .room           (room),
    .push           (push),
    .pkt            (wr_pkt)
  );

  dpd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_pkt (wr_pkt),
    .room   (room),
    .pop    (pop),
    .avail  (avail),
    .rd_pkt (rd_pkt)
  );

  dpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (avail),
    .pkt       (rd_pkt),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

@@ sv/dpd_checker.sv @@
// port-level checks for the position packet decoder
module dpd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [151:0] m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result waiting");

  a_low_bits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] == 4'd0 && m_tdata[35:20] == 16'd0 &&
                 m_tdata[55:52] == 4'd0 && m_tdata[87:72] == 16'd0)
    else $error("element low bits not zero");

endmodule

bind delta_position_packet_decoder_unit dpd_checker u_dpd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
